// ----- hdl/ba_pkg.sv -----
// ----------------------------------------------------------------------------
// ba_pkg
// Shared types and codes for the buddy allocator controller and datapath.
// ----------------------------------------------------------------------------
`default_nettype none

package ba_pkg;

   localparam logic [1:0] OP_ALLOC = 2'd0;
   localparam logic [1:0] OP_FREE  = 2'd1;
   localparam logic [1:0] OP_COUNT = 2'd2;

   localparam logic CSR_ENABLE = 1'b0;
   localparam logic CSR_BASE   = 1'b1;

   typedef struct packed {
      logic load;
      logic clr_step;
      logic alloc_init;
      logic scan_rd;
      logic scan_next;
      logic take;
      logic split;
      logic mark;
      logic free_rd;
      logic free_init;
      logic merge_rd;
      logic merge_step;
      logic merge_end;
      logic cnt_step;
      logic res_fail;
      logic res_count;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic clr_last;
      logic alloc_ok;
      logic hit;
      logic at_want;
      logic free_ok;
      logic at_top;
      logic cnt_end;
      logic rsp_busy;
   } status_type;

endpackage

`default_nettype wire

// ----- hdl/ba_ctrl.sv -----
// ----------------------------------------------------------------------------
// ba_ctrl
// Sequencer for allocate, free and count; drives datapath commands.
// ----------------------------------------------------------------------------
`default_nettype none

module ba_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   input  wire logic [1:0]          req_operation,
   output logic                     req_stall,
   input  wire ba_pkg::status_type  st,
   output ba_pkg::cmd_type          cmd
);
   import ba_pkg::*;

   localparam logic [3:0] S_CLEAR = 4'd0;
   localparam logic [3:0] S_IDLE  = 4'd1;
   localparam logic [3:0] S_ACHK  = 4'd2;
   localparam logic [3:0] S_SRD   = 4'd3;
   localparam logic [3:0] S_SCHK  = 4'd4;
   localparam logic [3:0] S_TAKE  = 4'd5;
   localparam logic [3:0] S_SPLIT = 4'd6;
   localparam logic [3:0] S_FRD   = 4'd7;
   localparam logic [3:0] S_FCHK  = 4'd8;
   localparam logic [3:0] S_FINIT = 4'd9;
   localparam logic [3:0] S_MRD   = 4'd10;
   localparam logic [3:0] S_MCHK  = 4'd11;
   localparam logic [3:0] S_COUNT = 4'd12;
   localparam logic [3:0] S_DONE  = 4'd13;

   logic [3:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (st.clr_last) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               case (req_operation)
                  OP_ALLOC: state_in = S_ACHK;
                  OP_FREE:  state_in = S_FRD;
                  OP_COUNT: state_in = S_COUNT;
                  default: begin
                     cmd.res_fail = 1'b1;
                     state_in     = S_DONE;
                  end
               endcase
            end
         end
         S_ACHK: begin
            if (st.alloc_ok) begin
               cmd.alloc_init = 1'b1;
               state_in       = S_SRD;
            end else begin
               cmd.res_fail = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_SRD: begin
            cmd.scan_rd = 1'b1;
            state_in    = S_SCHK;
         end
         S_SCHK: begin
            if (st.hit) begin
               state_in = S_TAKE;
            end else begin
               cmd.scan_next = 1'b1;
               state_in      = S_SRD;
            end
         end
         S_TAKE: begin
            cmd.take = 1'b1;
            state_in = S_SPLIT;
         end
         S_SPLIT: begin
            if (st.at_want) begin
               cmd.mark = 1'b1;
               state_in = S_DONE;
            end else begin
               cmd.split = 1'b1;
            end
         end
         S_FRD: begin
            cmd.free_rd = 1'b1;
            state_in    = S_FCHK;
         end
         S_FCHK: begin
            if (st.free_ok) begin
               state_in = S_FINIT;
            end else begin
               cmd.res_fail = 1'b1;
               state_in     = S_DONE;
            end
         end
         S_FINIT: begin
            cmd.free_init = 1'b1;
            state_in      = S_MRD;
         end
         S_MRD: begin
            if (st.at_top) begin
               cmd.merge_end = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.merge_rd = 1'b1;
               state_in     = S_MCHK;
            end
         end
         S_MCHK: begin
            if (st.hit) begin
               cmd.merge_step = 1'b1;
               state_in       = S_MRD;
            end else begin
               cmd.merge_end = 1'b1;
               state_in      = S_DONE;
            end
         end
         S_COUNT: begin
            if (st.cnt_end) begin
               cmd.res_count = 1'b1;
               state_in      = S_DONE;
            end else begin
               cmd.cnt_step = 1'b1;
            end
         end
         S_DONE: begin
            if (!st.rsp_busy) begin
               cmd.emit = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) state_ff <= S_CLEAR;
      else       state_ff <= state_in;
   end

endmodule

`default_nettype wire

// ----- hdl/ba_datapath.sv -----
// ----------------------------------------------------------------------------
// ba_datapath
// Free-mark tree, leaf tables, per-order free counters and result registers.
// ----------------------------------------------------------------------------
`default_nettype none

module ba_datapath #(
   parameter int MAX_ORDER_LEVEL = 10,
   parameter int MIN_BLOCK       = 32,
   parameter int HEADER_BYTES    = 16,
   parameter int TASK_BITS       = 4
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ba_pkg::cmd_type    cmd,
   output ba_pkg::status_type      st,
   input  wire logic               csr_valid,
   input  wire logic               csr_index,
   input  wire logic [31:0]        csr_data,
   input  wire logic [15:0]        req_request_size,
   input  wire logic [31:0]        req_data_address,
   input  wire logic [3:0]         req_task_id,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic                    rsp_status,
   output logic [31:0]             rsp_result_address,
   output logic [10:0]            rsp_free_count
);
   import ba_pkg::*;

   localparam int L      = MAX_ORDER_LEVEL;
   localparam int NW     = L + 1;
   localparam int NODES  = (2 << L) - 1;
   localparam int LEAVES = 1 << L;
   localparam int OW     = $clog2(L + 2);
   localparam int CW     = L + 1;
   localparam int LOGMIN = $clog2(MIN_BLOCK);
   localparam logic [OW-1:0] OMAX = OW'(L);

   function automatic logic [NW-1:0] node_of(input logic [OW-1:0] o, input logic [L-1:0] b);
      logic [NW-1:0] base;
      base = (NW'(1) << (NW'(L) - NW'(o))) - NW'(1);
      return base + NW'(b);
   endfunction

   logic                 enabled_ff;
   logic [31:0]          base_ff;
   logic [15:0]          size_ff;
   logic [31:0]          addr_ff;
   logic [TASK_BITS-1:0] owner_ff;
   logic [OW-1:0]        want_ff, lim_ff, o_ff;
   logic [L-1:0]         blk_ff;
   logic [CW-1:0]        acc_ff;
   logic [CW-1:0]        cnt_ff [0:L];
   logic [NW-1:0]        clr_ff;
   logic                 rd_free_ff, rd_start_ff;
   logic [TASK_BITS-1:0] rd_owner_ff;
   logic [OW-1:0]        rd_order_ff;
   logic                 res_status_ff;
   logic [31:0]          res_addr_ff;
   logic [10:0]          res_count_ff;
   logic                 rsp_valid_ff;
   logic                 rsp_status_ff;
   logic [31:0]          rsp_addr_ff;
   logic [10:0]          rsp_count_ff;

   logic                 free_mem  [0:NODES-1];
   logic                 start_mem [0:LEAVES-1];
   logic [OW-1:0]        order_mem [0:LEAVES-1];
   logic [TASK_BITS-1:0] owner_mem [0:LEAVES-1];

   // size to order
   logic [31:0]   want_sz, lim_sz;
   logic [OW-1:0] want_c, lim_c;
   always_comb begin
      want_sz = 32'(req_request_size) + 32'(HEADER_BYTES);
      lim_sz  = 32'(req_request_size);
      want_c  = '0;
      lim_c   = '0;
      for (int i = 0; i <= L; i++) begin
         if ((32'(MIN_BLOCK) << i) < want_sz) want_c = want_c + OW'(1);
         if ((32'(MIN_BLOCK) << i) < lim_sz)  lim_c  = lim_c + OW'(1);
      end
   end

   logic [OW-1:0] found_o;
   logic          found_any;
   always_comb begin
      found_o   = OMAX;
      found_any = 1'b0;
      for (int i = L; i >= 0; i--) begin
         if (OW'(i) >= want_ff && cnt_ff[i] != '0) begin
            found_o   = OW'(i);
            found_any = 1'b1;
         end
      end
   end

   // free checks
   logic [31:0]   off;
   logic [L-1:0]  leaf;
   logic          aligned, in_range;
   logic [OW-1:0] fo;
   always_comb begin
      off      = addr_ff - 32'(HEADER_BYTES) - base_ff;
      leaf     = off[LOGMIN +: L];
      aligned  = (off & 32'(MIN_BLOCK - 1)) == 32'd0;
      in_range = (off >> (LOGMIN + L)) == 32'd0;
      fo       = (rd_order_ff > OMAX) ? OMAX : rd_order_ff;
   end

   logic [OW-1:0] om1;
   logic [L-1:0]  alloc_leaf;
   assign om1        = o_ff - OW'(1);
   assign alloc_leaf = blk_ff << want_ff;

   // free-mark port
   logic          fw_en, fw_data;
   logic [NW-1:0] fw_addr, fr_addr;
   logic          inc_en, dec_en;
   logic [OW-1:0] inc_idx, dec_idx;
   always_comb begin
      fw_en   = 1'b0;
      fw_data = 1'b0;
      fw_addr = node_of(o_ff, blk_ff);
      inc_en  = 1'b0;
      dec_en  = 1'b0;
      inc_idx = o_ff;
      dec_idx = o_ff;
      fr_addr = cmd.merge_rd ? node_of(o_ff, blk_ff ^ L'(1)) : node_of(o_ff, blk_ff);
      if (cmd.clr_step) begin
         fw_en   = 1'b1;
         fw_addr = clr_ff;
         fw_data = (clr_ff == '0);
      end else if (cmd.take) begin
         fw_en  = 1'b1;
         dec_en = 1'b1;
      end else if (cmd.split) begin
         fw_en   = 1'b1;
         fw_data = 1'b1;
         fw_addr = node_of(om1, (blk_ff << 1) | L'(1));
         inc_en  = 1'b1;
         inc_idx = om1;
      end else if (cmd.merge_step) begin
         fw_en   = 1'b1;
         fw_addr = node_of(o_ff, blk_ff ^ L'(1));
         dec_en  = 1'b1;
      end else if (cmd.merge_end) begin
         fw_en   = 1'b1;
         fw_data = 1'b1;
         inc_en  = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (fw_en) free_mem[fw_addr] <= fw_data;
      if (cmd.scan_rd || cmd.merge_rd) rd_free_ff <= free_mem[fr_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clr_step && clr_ff < NW'(LEAVES)) start_mem[clr_ff[L-1:0]] <= 1'b0;
      else if (cmd.mark) start_mem[alloc_leaf] <= 1'b1;
      else if (cmd.free_init) start_mem[leaf] <= 1'b0;
      if (cmd.mark) begin
         order_mem[alloc_leaf] <= want_ff;
         owner_mem[alloc_leaf] <= owner_ff;
      end
      if (cmd.free_rd) begin
         rd_start_ff <= start_mem[leaf];
         rd_order_ff <= order_mem[leaf];
         rd_owner_ff <= owner_mem[leaf];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i <= L; i++) cnt_ff[i] <= (i == L) ? CW'(1) : '0;
      end else begin
         for (int i = 0; i <= L; i++) begin
            if (inc_en && inc_idx == OW'(i)) cnt_ff[i] <= cnt_ff[i] + CW'(1);
            else if (dec_en && dec_idx == OW'(i)) cnt_ff[i] <= cnt_ff[i] - CW'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff     <= '0;
         enabled_ff <= 1'b0;
         base_ff    <= '0;
      end else begin
         if (cmd.clr_step) clr_ff <= clr_ff + NW'(1);
         if (csr_valid) begin
            if (csr_index == CSR_ENABLE) enabled_ff <= csr_data[0];
            else                         base_ff    <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         size_ff  <= req_request_size;
         addr_ff  <= req_data_address;
         owner_ff <= TASK_BITS'(req_task_id);
         want_ff  <= want_c;
         lim_ff   <= lim_c;
         o_ff     <= '0;
         acc_ff   <= '0;
      end
      if (cmd.alloc_init) begin
         o_ff   <= found_o;
         blk_ff <= '0;
      end
      if (cmd.scan_next) blk_ff <= blk_ff + L'(1);
      if (cmd.split) begin
         o_ff   <= om1;
         blk_ff <= blk_ff << 1;
      end
      if (cmd.free_init) begin
         o_ff   <= fo;
         blk_ff <= leaf >> fo;
      end
      if (cmd.merge_step) begin
         o_ff   <= o_ff + OW'(1);
         blk_ff <= blk_ff >> 1;
      end
      if (cmd.cnt_step) begin
         acc_ff <= acc_ff + cnt_ff[o_ff[OW-1:0]];
         o_ff   <= o_ff + OW'(1);
      end
   end

   logic [31:0] acc32;
   assign acc32 = 32'(acc_ff);

   always_ff @(posedge clock) begin
      if (cmd.res_fail) begin
         res_status_ff <= 1'b1;
         res_addr_ff   <= '0;
         res_count_ff  <= '0;
      end else if (cmd.mark) begin
         res_status_ff <= 1'b0;
         res_addr_ff   <= base_ff + (32'(alloc_leaf) << LOGMIN) + 32'(HEADER_BYTES);
         res_count_ff  <= '0;
      end else if (cmd.merge_end) begin
         res_status_ff <= 1'b0;
         res_addr_ff   <= '0;
         res_count_ff  <= '0;
      end else if (cmd.res_count) begin
         res_status_ff <= 1'b0;
         res_addr_ff   <= '0;
         if (!enabled_ff)           res_count_ff <= '0;
         else if (acc32 > 32'd2047) res_count_ff <= 11'h7ff;
         else                       res_count_ff <= acc32[10:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset)          rsp_valid_ff <= 1'b0;
      else if (cmd.emit)  rsp_valid_ff <= 1'b1;
      else if (!rsp_stall) rsp_valid_ff <= 1'b0;
      if (cmd.emit) begin
         rsp_status_ff <= res_status_ff;
         rsp_addr_ff   <= res_addr_ff;
         rsp_count_ff  <= res_count_ff;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_result_address = rsp_addr_ff;
   assign rsp_free_count     = rsp_count_ff;

   always_comb begin
      st          = '0;
      st.clr_last = (clr_ff == NW'(NODES - 1));
      st.alloc_ok = enabled_ff && (size_ff != '0) && (want_ff <= OMAX) && found_any;
      st.hit      = rd_free_ff;
      st.at_want  = (o_ff == want_ff);
      st.free_ok  = (addr_ff != '0) && aligned && in_range && rd_start_ff
                    && (rd_owner_ff == owner_ff);
      st.at_top   = (o_ff >= OMAX);
      st.cnt_end  = (o_ff >= lim_ff) || (o_ff > OMAX);
      st.rsp_busy = rsp_valid_ff && rsp_stall;
   end

   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      cmd.take |-> cnt_ff[dec_idx] != '0) else $error("free counter underflow");
   a_split_above_want: assert property (@(posedge clock) disable iff (reset)
      cmd.split |-> o_ff > want_ff) else $error("split below requested order");
   a_merge_in_tree: assert property (@(posedge clock) disable iff (reset)
      cmd.merge_step |-> o_ff < OMAX) else $error("merge past root");

endmodule

`default_nettype wire

// ----- hdl/buddy_allocator_top.sv -----
// ----------------------------------------------------------------------------
// buddy_allocator_top
// Buddy allocator with a controller and a mark-tree datapath.
// ----------------------------------------------------------------------------
// One request at a time. After reset a clearing pass over the free-mark memory
// runs before the first request is taken. An allocate checks the request, then
// scans the free-mark memory at the chosen order block by block and splits down
// to the requested order, or goes straight to its result when it fails its first
// checks; free reads the leaf tables, checks the pointer (and fails if the check
// fails), then merges with each free buddy until a buddy is in use or merging
// reaches the root; count adds up the per-order free counters, one order at a
// time. A result is held in an output register, so the next request is taken
// while it waits.
`default_nettype none

module buddy_allocator_top #(
   parameter int MAX_ORDER_LEVEL = 10,
   parameter int MIN_BLOCK       = 32,
   parameter int HEADER_BYTES    = 16,
   parameter int TASK_BITS       = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_stall,
   input  wire logic [1:0]  req_operation,
   input  wire logic [15:0] req_request_size,
   input  wire logic [31:0] req_data_address,
   input  wire logic [3:0]  req_task_id,
   output logic             rsp_valid,
   input  wire logic        rsp_stall,
   output logic             rsp_status,
   output logic [31:0]      rsp_result_address,
   output logic [10:0]      rsp_free_count,
   input  wire logic        csr_valid,
   output logic             csr_ready,
   input  wire logic        csr_index,
   input  wire logic [31:0] csr_data
);
   import ba_pkg::*;

   cmd_type    cmd;
   status_type st;

   assign csr_ready = 1'b1;

   ba_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_operation (req_operation),
      .req_stall     (req_stall),
      .st            (st),
      .cmd           (cmd)
   );

   ba_datapath #(
      .MAX_ORDER_LEVEL (MAX_ORDER_LEVEL),
      .MIN_BLOCK       (MIN_BLOCK),
      .HEADER_BYTES    (HEADER_BYTES),
      .TASK_BITS       (TASK_BITS)
   ) u_dp (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .st                 (st),
      .csr_valid          (csr_valid),
      .csr_index          (csr_index),
      .csr_data           (csr_data),
      .req_request_size   (req_request_size),
      .req_data_address   (req_data_address),
      .req_task_id        (req_task_id),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_result_address (rsp_result_address),
      .rsp_free_count     (rsp_free_count)
   );

endmodule

`default_nettype wire
